// ===== rtl/card_access_check_with_log_macros.svh =====
// Assertion macros shared by the card access check RTL
`ifndef CARD_ACCESS_CHECK_WITH_LOG_MACROS_SVH
`define CARD_ACCESS_CHECK_WITH_LOG_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define CACL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define CACL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/cacl_pkg.sv =====
// Shared types and constants of the card access check block
package cacl_pkg;

  localparam int OP_W      = 3;
  localparam int LEN_W     = 4;
  localparam int TIME_W    = 32;
  localparam int STATUS_W  = 2;
  localparam int THR_W     = 8;
  localparam logic [THR_W-1:0] THR_RESET = 8'd115;

  // request opcodes
  typedef enum logic [OP_W-1:0] {
    OP_SCAN     = 3'd0,
    OP_ADD      = 3'd1,
    OP_CLR_CARD = 3'd2,
    OP_CLR_LOG  = 3'd3,
    OP_READ_LOG = 3'd4
  } op_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STS_DONE    = 2'd0,
    STS_FULL    = 2'd1,
    STS_BAD_LEN = 2'd2,
    STS_RANGE   = 2'd3
  } status_t;

  // sequencer states, one-hot
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SRCH  = 6'b000010,
    ST_APPLY = 6'b000100,
    ST_RDREQ = 6'b001000,
    ST_RDDAT = 6'b010000,
    ST_FIN   = 6'b100000
  } state_t;

  // comparator result back to the sequencer
  typedef struct packed {
    logic vld;
    logic hit;
  } match_res_t;

endpackage

// ===== rtl/cacl_ram.sv =====
// Generic single-write, single-read RAM with registered read data
module cacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

// ===== rtl/cacl_match.sv =====
// Shared identifier comparator used by the table search, one entry per cycle
module cacl_match #(
  parameter int UIDW = 56
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic [UIDW-1:0]               entry_uid,
  input  logic [cacl_pkg::LEN_W-1:0]    entry_len,
  input  logic [UIDW-1:0]               key_uid,
  input  logic [cacl_pkg::LEN_W-1:0]    key_len,
  output cacl_pkg::match_res_t          res_r
);

  logic eq;

  // length and masked bytes must both agree
  assign eq = (entry_len == key_len) && (entry_uid == key_uid);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r.vld <= 1'b0;
      res_r.hit <= 1'b0;
    end else begin
      res_r.vld <= en;
      res_r.hit <= en && eq;
    end
  end

endmodule

// ===== rtl/card_access_check_with_log.sv =====
// Top level: card table search, ring scan log and request sequencer
// Scan and add walk the N cards held until a hit; an empty table or a bad-length scan
//   skips the walk; one table entry compared per cycle.
// Read log does one log RAM read; clears, bad-length adds and unknown ops go straight to finish.
// One request at a time; the next is taken the cycle after a result loads.
// Synchronous active-low reset clears counts, pointers, threshold (115); RAMs are not swept.
`include "card_access_check_with_log_macros.svh"

module card_access_check_with_log #(
  parameter int CARD_DEPTH = 128,
  parameter int LOG_DEPTH  = 128,
  parameter int UID_BYTES  = 7
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // request channel
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [cacl_pkg::OP_W-1:0]              in_op,
  input  logic [8*UID_BYTES-1:0]                 in_uid,
  input  logic [cacl_pkg::LEN_W-1:0]             in_uid_len,
  input  logic [cacl_pkg::TIME_W-1:0]            in_timestamp,
  input  logic [$clog2(LOG_DEPTH)-1:0]           in_log_index,
  // result channel
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [cacl_pkg::STATUS_W-1:0]          out_status,
  output logic                                   out_allowed,
  output logic [$clog2(CARD_DEPTH+1)-1:0]        out_card_count,
  output logic [$clog2(LOG_DEPTH+1)-1:0]         out_log_count,
  output logic [8*UID_BYTES-1:0]                 out_rec_uid,
  output logic [cacl_pkg::LEN_W-1:0]             out_rec_uid_len,
  output logic [cacl_pkg::TIME_W-1:0]            out_rec_time,
  output logic                                   out_rec_allowed,
  // threshold register write
  input  logic                                   cfg_wr_en,
  input  logic [cacl_pkg::THR_W-1:0]             cfg_wr_data
);

  localparam int UIDW = 8 * UID_BYTES;
  localparam int LENW = cacl_pkg::LEN_W;
  localparam int TW   = cacl_pkg::TIME_W;
  localparam int CAW  = (CARD_DEPTH > 1) ? $clog2(CARD_DEPTH) : 1;
  localparam int CCW  = $clog2(CARD_DEPTH + 1);
  localparam int LAW  = $clog2(LOG_DEPTH);
  localparam int LCW  = $clog2(LOG_DEPTH + 1);
  localparam int CW   = (LCW > cacl_pkg::THR_W) ? LCW : cacl_pkg::THR_W;
  localparam int CEW  = UIDW + LENW;
  localparam int LEW  = UIDW + LENW + TW + 1;

  // byte mask for the first len bytes of an identifier
  function automatic logic [UIDW-1:0] uid_mask(input logic [LENW-1:0] len);
    logic [UIDW-1:0] m;
    m = '0;
    for (int b = 0; b < UID_BYTES; b++) begin
      if (LENW'(b) < len) begin
        m[8*b +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

  function automatic logic len_ok(input logic [LENW-1:0] len);
    return (len != '0) && (len <= LENW'(UID_BYTES));
  endfunction

  function automatic logic [LAW-1:0] ptr_inc(input logic [LAW-1:0] p);
    return (p == LAW'(LOG_DEPTH - 1)) ? '0 : p + LAW'(1);
  endfunction

  // control state
  cacl_pkg::state_t            state_r, state_nxt;
  logic [cacl_pkg::THR_W-1:0]  thr_r, thr_nxt;
  logic [CCW-1:0]              card_total_r, card_total_nxt;
  logic [LAW-1:0]              log_head_r, log_head_nxt;
  logic [LAW-1:0]              log_tail_r, log_tail_nxt;
  logic [LCW-1:0]              log_total_r, log_total_nxt;
  logic [CCW-1:0]              iss_r, iss_nxt;
  logic                        v1_r, v1_nxt;
  logic                        found_r, found_nxt;
  logic                        out_valid_r, out_valid_nxt;

  // request and result payload
  logic [cacl_pkg::OP_W-1:0]   op_r, op_nxt;
  logic [UIDW-1:0]             key_uid_r, key_uid_nxt;
  logic [LENW-1:0]             key_len_r, key_len_nxt;
  logic [TW-1:0]               ts_r, ts_nxt;
  logic [LAW-1:0]              idx_r, idx_nxt;
  logic [cacl_pkg::STATUS_W-1:0] res_status_r, res_status_nxt;
  logic                        res_allowed_r, res_allowed_nxt;
  logic [UIDW-1:0]             res_uid_r, res_uid_nxt;
  logic [LENW-1:0]             res_len_r, res_len_nxt;
  logic [TW-1:0]               res_time_r, res_time_nxt;
  logic                        res_grant_r, res_grant_nxt;
  logic [cacl_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic                        out_allowed_r, out_allowed_nxt;
  logic [CCW-1:0]              out_card_count_r, out_card_count_nxt;
  logic [LCW-1:0]              out_log_count_r, out_log_count_nxt;
  logic [UIDW-1:0]             out_rec_uid_r, out_rec_uid_nxt;
  logic [LENW-1:0]             out_rec_len_r, out_rec_len_nxt;
  logic [TW-1:0]               out_rec_time_r, out_rec_time_nxt;
  logic                        out_rec_grant_r, out_rec_grant_nxt;

  // memories and comparator
  logic                        card_we;
  logic [CEW-1:0]              card_rdata;
  logic                        log_we;
  logic [LEW-1:0]              log_rdata;
  logic [LAW:0]                rd_sum;
  logic [LAW-1:0]              log_raddr;
  cacl_pkg::match_res_t        m_res;

  // scan log drop and search issue
  logic                        drop;
  logic                        issue;

  cacl_ram #(
    .WIDTH (CEW),
    .DEPTH (CARD_DEPTH)
  ) u_card_ram (
    .clk     (clk),
    .we      (card_we),
    .waddr   (card_total_r[CAW-1:0]),
    .wdata   ({key_len_r, key_uid_r}),
    .raddr   (iss_r[CAW-1:0]),
    .rdata_r (card_rdata)
  );

  cacl_ram #(
    .WIDTH (LEW),
    .DEPTH (LOG_DEPTH)
  ) u_log_ram (
    .clk     (clk),
    .we      (log_we),
    .waddr   (log_head_r),
    .wdata   ({found_r, ts_r, key_len_r, key_uid_r}),
    .raddr   (log_raddr),
    .rdata_r (log_rdata)
  );

  cacl_match #(
    .UIDW (UIDW)
  ) u_match (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (v1_r),
    .entry_uid (card_rdata[UIDW-1:0]),
    .entry_len (card_rdata[CEW-1:UIDW]),
    .key_uid   (key_uid_r),
    .key_len   (key_len_r),
    .res_r     (m_res)
  );

  // age index to ring address, one wrap correction
  assign rd_sum    = {1'b0, log_tail_r} + {1'b0, idx_r};
  assign log_raddr = (rd_sum >= (LAW+1)'(LOG_DEPTH)) ?
                     LAW'(rd_sum - (LAW+1)'(LOG_DEPTH)) : rd_sum[LAW-1:0];

  // oldest record goes when the log is at threshold or full
  assign drop = (log_total_r != '0) &&
                ((CW'(log_total_r) >= CW'(thr_r)) || (log_total_r >= LCW'(LOG_DEPTH)));

  assign issue = (iss_r < card_total_r) && !found_r && !m_res.hit;

  // sequencer and datapath next state
  always_comb begin
    state_nxt          = state_r;
    thr_nxt            = thr_r;
    card_total_nxt     = card_total_r;
    log_head_nxt       = log_head_r;
    log_tail_nxt       = log_tail_r;
    log_total_nxt      = log_total_r;
    iss_nxt            = iss_r;
    v1_nxt             = 1'b0;
    found_nxt          = found_r;
    out_valid_nxt      = out_valid_r;
    op_nxt             = op_r;
    key_uid_nxt        = key_uid_r;
    key_len_nxt        = key_len_r;
    ts_nxt             = ts_r;
    idx_nxt            = idx_r;
    res_status_nxt     = res_status_r;
    res_allowed_nxt    = res_allowed_r;
    res_uid_nxt        = res_uid_r;
    res_len_nxt        = res_len_r;
    res_time_nxt       = res_time_r;
    res_grant_nxt      = res_grant_r;
    out_status_nxt     = out_status_r;
    out_allowed_nxt    = out_allowed_r;
    out_card_count_nxt = out_card_count_r;
    out_log_count_nxt  = out_log_count_r;
    out_rec_uid_nxt    = out_rec_uid_r;
    out_rec_len_nxt    = out_rec_len_r;
    out_rec_time_nxt   = out_rec_time_r;
    out_rec_grant_nxt  = out_rec_grant_r;
    card_we            = 1'b0;
    log_we             = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cfg_wr_en) begin
      thr_nxt = cfg_wr_data;
    end

    unique case (state_r)
      cacl_pkg::ST_IDLE: begin
        if (in_valid) begin
          op_nxt          = in_op;
          key_uid_nxt     = in_uid & uid_mask(in_uid_len);
          key_len_nxt     = in_uid_len;
          ts_nxt          = in_timestamp;
          idx_nxt         = in_log_index;
          found_nxt       = 1'b0;
          iss_nxt         = '0;
          res_status_nxt  = cacl_pkg::STS_DONE;
          res_allowed_nxt = 1'b0;
          res_uid_nxt     = '0;
          res_len_nxt     = '0;
          res_time_nxt    = '0;
          res_grant_nxt   = 1'b0;
          unique case (in_op)
            cacl_pkg::OP_SCAN: begin
              state_nxt = (len_ok(in_uid_len) && card_total_r != '0) ?
                          cacl_pkg::ST_SRCH : cacl_pkg::ST_APPLY;
            end
            cacl_pkg::OP_ADD: begin
              if (!len_ok(in_uid_len)) begin
                res_status_nxt = cacl_pkg::STS_BAD_LEN;
                state_nxt      = cacl_pkg::ST_FIN;
              end else begin
                state_nxt = (card_total_r != '0) ? cacl_pkg::ST_SRCH : cacl_pkg::ST_APPLY;
              end
            end
            cacl_pkg::OP_CLR_CARD: begin
              card_total_nxt = '0;
              state_nxt      = cacl_pkg::ST_FIN;
            end
            cacl_pkg::OP_CLR_LOG: begin
              log_head_nxt  = '0;
              log_tail_nxt  = '0;
              log_total_nxt = '0;
              state_nxt     = cacl_pkg::ST_FIN;
            end
            cacl_pkg::OP_READ_LOG: begin
              if (CW'(in_log_index) >= CW'(log_total_r)) begin
                res_status_nxt = cacl_pkg::STS_RANGE;
                state_nxt      = cacl_pkg::ST_FIN;
              end else begin
                state_nxt = cacl_pkg::ST_RDREQ;
              end
            end
            default: begin
              state_nxt = cacl_pkg::ST_FIN;
            end
          endcase
        end
      end

      // walk the table: issue one read per cycle, compare each entry in the cycle after its read
      cacl_pkg::ST_SRCH: begin
        if (issue) begin
          v1_nxt  = 1'b1;
          iss_nxt = iss_r + CCW'(1);
        end
        if (m_res.hit) begin
          found_nxt = 1'b1;
          state_nxt = cacl_pkg::ST_APPLY;
        end else if (!issue && !v1_r && !m_res.vld) begin
          state_nxt = cacl_pkg::ST_APPLY;
        end
      end

      // commit a scan to the log or an add to the table
      cacl_pkg::ST_APPLY: begin
        unique case (op_r)
          cacl_pkg::OP_SCAN: begin
            res_allowed_nxt = found_r;
            log_we          = 1'b1;
            log_head_nxt    = ptr_inc(log_head_r);
            if (drop) begin
              log_tail_nxt  = ptr_inc(log_tail_r);
            end
            log_total_nxt = log_total_r + LCW'(1) - (drop ? LCW'(1) : LCW'(0));
          end
          cacl_pkg::OP_ADD: begin
            if (!found_r) begin
              if (card_total_r >= CCW'(CARD_DEPTH)) begin
                res_status_nxt = cacl_pkg::STS_FULL;
              end else begin
                card_we        = 1'b1;
                card_total_nxt = card_total_r + CCW'(1);
              end
            end
          end
          default: begin
          end
        endcase
        state_nxt = cacl_pkg::ST_FIN;
      end

      cacl_pkg::ST_RDREQ: begin
        state_nxt = cacl_pkg::ST_RDDAT;
      end

      cacl_pkg::ST_RDDAT: begin
        res_uid_nxt   = log_rdata[UIDW-1:0];
        res_len_nxt   = log_rdata[UIDW +: LENW];
        res_time_nxt  = log_rdata[UIDW+LENW +: TW];
        res_grant_nxt = log_rdata[LEW-1];
        state_nxt     = cacl_pkg::ST_FIN;
      end

      // hand the result over once the output register is free
      cacl_pkg::ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt      = 1'b1;
          out_status_nxt     = res_status_r;
          out_allowed_nxt    = res_allowed_r;
          out_card_count_nxt = card_total_r;
          out_log_count_nxt  = log_total_r;
          out_rec_uid_nxt    = res_uid_r;
          out_rec_len_nxt    = res_len_r;
          out_rec_time_nxt   = res_time_r;
          out_rec_grant_nxt  = res_grant_r;
          state_nxt          = cacl_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = cacl_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= cacl_pkg::ST_IDLE;
      thr_r        <= cacl_pkg::THR_RESET;
      card_total_r <= '0;
      log_head_r   <= '0;
      log_tail_r   <= '0;
      log_total_r  <= '0;
      iss_r        <= '0;
      v1_r         <= 1'b0;
      found_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      thr_r        <= thr_nxt;
      card_total_r <= card_total_nxt;
      log_head_r   <= log_head_nxt;
      log_tail_r   <= log_tail_nxt;
      log_total_r  <= log_total_nxt;
      iss_r        <= iss_nxt;
      v1_r         <= v1_nxt;
      found_r      <= found_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r             <= op_nxt;
    key_uid_r        <= key_uid_nxt;
    key_len_r        <= key_len_nxt;
    ts_r             <= ts_nxt;
    idx_r            <= idx_nxt;
    res_status_r     <= res_status_nxt;
    res_allowed_r    <= res_allowed_nxt;
    res_uid_r        <= res_uid_nxt;
    res_len_r        <= res_len_nxt;
    res_time_r       <= res_time_nxt;
    res_grant_r      <= res_grant_nxt;
    out_status_r     <= out_status_nxt;
    out_allowed_r    <= out_allowed_nxt;
    out_card_count_r <= out_card_count_nxt;
    out_log_count_r  <= out_log_count_nxt;
    out_rec_uid_r    <= out_rec_uid_nxt;
    out_rec_len_r    <= out_rec_len_nxt;
    out_rec_time_r   <= out_rec_time_nxt;
    out_rec_grant_r  <= out_rec_grant_nxt;
  end

  assign in_stall        = (state_r != cacl_pkg::ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_allowed     = out_allowed_r;
  assign out_card_count  = out_card_count_r;
  assign out_log_count   = out_log_count_r;
  assign out_rec_uid     = out_rec_uid_r;
  assign out_rec_uid_len = out_rec_len_r;
  assign out_rec_time    = out_rec_time_r;
  assign out_rec_allowed = out_rec_grant_r;

  // checks
  `CACL_ASSERT_IMP(a_card_bound, 1'b1, card_total_r <= CCW'(CARD_DEPTH),
                   "card count over depth")
  `CACL_ASSERT_IMP(a_log_bound, 1'b1, log_total_r <= LCW'(LOG_DEPTH),
                   "log count over depth")
  `CACL_ASSERT_IMP(a_out_from_fin, $rose(out_valid_r),
                   $past(state_r == cacl_pkg::ST_FIN), "result without finish")
  `CACL_ASSERT_NXT(a_scan_logs,
                   (state_r == cacl_pkg::ST_APPLY) && (op_r == cacl_pkg::OP_SCAN),
                   log_total_r != '0, "scan left log empty")
  `CACL_ASSERT_IMP(a_srch_len, state_r == cacl_pkg::ST_SRCH, len_ok(key_len_r),
                   "search with bad length")

endmodule
